/* hdl/ffha_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_pkg
// Types and constants shared by the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

	// byte addresses are carried wide and signed so that underflow never aliases
	localparam int ADDR_W = 40;
	typedef logic signed [ADDR_W-1:0] addr_t;

	localparam addr_t WORD_B   = addr_t'(4);
	localparam addr_t DWORD_B  = addr_t'(8);
	localparam addr_t MIN_BLK  = addr_t'(16);
	localparam logic [31:0] SIZE_MASK = 32'hFFFF_FFF8;
	localparam logic [31:0] ALLOC_BIT = 32'h0000_0001;
	localparam logic [31:0] PRO_WORD  = 32'h0000_0009;

	localparam logic FN_ALLOC = 1'b0;
	localparam logic FN_FREE  = 1'b1;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic        func;
		logic [15:0] request_bytes;
		logic [15:0] release_offset;
	} ffha_req_t;

	typedef struct packed {
		logic [15:0] block_offset;
		logic [1:0]  status;
	} ffha_rsp_t;

	typedef enum logic [1:0] {
		MODE_INIT,
		MODE_ALLOC,
		MODE_FREE
	} mode_t;

	typedef enum logic [5:0] {
		S_CLR, S_IDLE,
		S_F0, S_F1, S_F2,
		S_A0, S_A1,
		S_G0, S_G1, S_G2,
		S_M0, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6,
		S_MA1, S_MA2, S_MA3,
		S_MB1, S_MB2, S_MB3, S_MB4, S_MB5,
		S_MC1, S_MC2, S_MC3, S_MC4, S_MC5, S_MC6, S_MC7, S_MC8,
		S_MRET,
		S_C0, S_C1, S_C2A, S_C2B, S_C3B, S_C4B,
		S_DONE
	} state_t;

	function automatic addr_t bsize(input logic [31:0] w);
		bsize = addr_t'({8'd0, w & SIZE_MASK});
	endfunction

endpackage
`default_nettype wire

/* hdl/ffha_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module ffha_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16384
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

/* hdl/first_fit_heap_allocator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// Boundary-tag heap with first-fit search, split, grow and coalesce.
// ----------------------------------------------------------------------------
//  channel | direction | payload     | handshake
//  req     | in        | ffha_req_t  | req_valid / req_ready
//  rsp     | out       | ffha_rsp_t  | rsp_valid / rsp_ready
//
// One request at a time; every heap word access goes through one RAM with a
// registered read, so the time taken follows the number of accesses.
// Allocate walks one block header at a time, splits the fitting block when
// the rest is large enough, and grows the heap when no block fits.
// After reset the heap is swept, one word a cycle, then the first chunk is
// set up; req_ready stays low till then.
// A finished response waits in the output register while the next request
// is taken.
module first_fit_heap_allocator
	import ffha_pkg::*;
#(
	parameter int HEAP_BYTES  = 65536,
	parameter int CHUNK_BYTES = 4096
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_ready,
	input  wire ffha_req_t req,
	output logic           rsp_valid,
	input  wire logic      rsp_ready,
	output ffha_rsp_t      rsp
);

	localparam int WORDS = HEAP_BYTES / 4;
	localparam int IW    = $clog2(WORDS);
	localparam int BW    = $clog2(HEAP_BYTES) + 1;
	localparam addr_t HEAP_A  = addr_t'(HEAP_BYTES);
	localparam addr_t CHUNK_A = addr_t'(CHUNK_BYTES);

	state_t        state_q, state_d;
	mode_t         mode_q;
	logic [IW-1:0] clr_q;
	logic [BW-1:0] brk_q;
	addr_t         bp_q, p_q, n_q, sz_q, t_q;
	logic [16:0]   need_q;
	logic          pa_q, na_q;
	ffha_rsp_t     res_q, out_q;
	logic          out_valid_q;

	// memory port
	logic          wr_en;
	addr_t         wr_addr, wr_val, rd_addr;
	logic          ram_we;
	logic [IW-1:0] ram_waddr, ram_raddr;
	logic [31:0]   ram_wdata, ram_rdata;
	logic          rvalid_q, fwd_q;
	logic [31:0]   fwd_d_q;
	logic [31:0]   d;
	addr_t         bs;

	addr_t         brk_a, gw, gsz, need_a;
	logic          grow_fail, fits, split;
	logic [16:0]   need_new;
	logic          accept, done_load;

	function automatic logic in_heap(input addr_t a);
		in_heap = (a >= addr_t'(0)) && (a < HEAP_A);
	endfunction

	assign d      = !rvalid_q ? 32'd0 : (fwd_q ? fwd_d_q : ram_rdata);
	assign bs     = bsize(d);
	assign brk_a  = addr_t'(brk_q);
	assign gw     = t_q >>> 2;
	assign gsz    = (gw + addr_t'(gw[0])) <<< 2;
	assign grow_fail = (brk_a + gsz) > HEAP_A;
	assign need_a = addr_t'(need_q);
	assign fits   = !d[0] && (need_a <= bs);
	assign split  = !((bs < need_a) || ((bs - need_a) < MIN_BLK));
	assign need_new = (req.request_bytes <= 16'd8) ? 17'd16
		: ((17'(req.request_bytes) + 17'd15) & 17'h1FFF8);

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign done_load = (state_q == S_DONE) && (!out_valid_q || rsp_ready);
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLR:  if (clr_q == IW'(WORDS - 1)) state_d = S_G0;
			S_IDLE: begin
				if (accept) begin
					if (req.func == FN_FREE) state_d = S_F0;
					else if (req.request_bytes == 16'd0) state_d = S_DONE;
					else state_d = S_A0;
				end
			end
			S_F0:  state_d = S_F1;
			S_F1:  state_d = S_F2;
			S_F2:  state_d = S_M0;
			S_A0:  state_d = S_A1;
			S_A1: begin
				if (bs == addr_t'(0)) state_d = S_G0;
				else if (fits) state_d = S_C0;
			end
			S_G0: begin
				if (grow_fail) state_d = (mode_q == MODE_INIT) ? S_IDLE : S_DONE;
				else state_d = S_G1;
			end
			S_G1:  state_d = S_G2;
			S_G2:  state_d = S_M0;
			S_M0:  state_d = S_M1;
			S_M1:  state_d = S_M2;
			S_M2:  state_d = S_M3;
			S_M3:  state_d = S_M4;
			S_M4:  state_d = S_M5;
			S_M5:  state_d = S_M6;
			S_M6: begin
				if (pa_q && na_q) state_d = S_MRET;
				else if (pa_q) state_d = S_MA1;
				else if (na_q) state_d = S_MB1;
				else state_d = S_MC1;
			end
			S_MA1: state_d = S_MA2;
			S_MA2: state_d = S_MA3;
			S_MA3: state_d = S_MRET;
			S_MB1: state_d = S_MB2;
			S_MB2: state_d = S_MB3;
			S_MB3: state_d = S_MB4;
			S_MB4: state_d = S_MB5;
			S_MB5: state_d = S_MRET;
			S_MC1: state_d = S_MC2;
			S_MC2: state_d = S_MC3;
			S_MC3: state_d = S_MC4;
			S_MC4: state_d = S_MC5;
			S_MC5: state_d = S_MC6;
			S_MC6: state_d = S_MC7;
			S_MC7: state_d = S_MC8;
			S_MC8: state_d = S_MRET;
			S_MRET: begin
				unique case (mode_q)
					MODE_FREE:  state_d = S_DONE;
					MODE_ALLOC: state_d = S_C0;
					default:    state_d = S_IDLE;
				endcase
			end
			S_C0:  state_d = S_C1;
			S_C1:  state_d = split ? S_C2B : S_C2A;
			S_C2A: state_d = S_DONE;
			S_C2B: state_d = S_C3B;
			S_C3B: state_d = S_C4B;
			S_C4B: state_d = S_DONE;
			S_DONE: if (done_load) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// memory accesses; a write is ordered before the read issued in the same cycle
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_val  = '0;
		rd_addr = '0;
		unique case (state_q)
			S_F0:  rd_addr = bp_q - WORD_B;
			S_F1: begin
				wr_en = 1'b1; wr_addr = bp_q - WORD_B; wr_val = bs;
				rd_addr = bp_q - WORD_B;
			end
			S_F2: begin
				wr_en = 1'b1; wr_addr = bp_q + bs - DWORD_B; wr_val = t_q;
			end
			S_A0:  rd_addr = WORD_B;
			S_A1:  rd_addr = bp_q + bs - WORD_B;
			S_G0: begin
				wr_en = !grow_fail; wr_addr = brk_a - WORD_B; wr_val = gsz;
				rd_addr = brk_a - WORD_B;
			end
			S_G1: begin
				wr_en = 1'b1; wr_addr = bp_q + bs - DWORD_B; wr_val = t_q;
				rd_addr = bp_q - WORD_B;
			end
			S_G2: begin
				wr_en = 1'b1; wr_addr = bp_q + bs - WORD_B; wr_val = addr_t'(ALLOC_BIT);
			end
			S_M0:  rd_addr = bp_q - DWORD_B;
			S_M1:  rd_addr = bp_q - bs - WORD_B;
			S_M2:  rd_addr = p_q + bs - DWORD_B;
			S_M3:  rd_addr = bp_q - WORD_B;
			S_M4:  rd_addr = bp_q + bs - WORD_B;
			S_M5:  rd_addr = bp_q - WORD_B;
			S_M6:  rd_addr = (!pa_q && na_q) ? bp_q - DWORD_B : bp_q - WORD_B;
			S_MA1: rd_addr = bp_q + bs - WORD_B;
			S_MA2: begin
				wr_en = 1'b1; wr_addr = bp_q - WORD_B; wr_val = sz_q + bs;
				rd_addr = bp_q - WORD_B;
			end
			S_MA3: begin
				wr_en = 1'b1; wr_addr = bp_q + bs - DWORD_B; wr_val = sz_q;
			end
			S_MB1: rd_addr = bp_q - bs - WORD_B;
			S_MB2: rd_addr = bp_q - WORD_B;
			S_MB3: begin
				wr_en = 1'b1; wr_addr = bp_q + bs - DWORD_B; wr_val = sz_q;
				rd_addr = bp_q - DWORD_B;
			end
			S_MB4: begin
				wr_en = 1'b1; wr_addr = bp_q - bs - WORD_B; wr_val = sz_q;
				rd_addr = bp_q - DWORD_B;
			end
			S_MC1: rd_addr = bp_q - DWORD_B;
			S_MC2: rd_addr = bp_q - bs - WORD_B;
			S_MC3: rd_addr = n_q - WORD_B;
			S_MC4: rd_addr = n_q + bs - DWORD_B;
			S_MC5: rd_addr = bp_q - DWORD_B;
			S_MC6: begin
				wr_en = 1'b1; wr_addr = bp_q - bs - WORD_B; wr_val = sz_q;
				rd_addr = n_q - WORD_B;
			end
			S_MC7: begin
				wr_en = 1'b1; wr_addr = n_q + bs - DWORD_B; wr_val = sz_q;
				rd_addr = bp_q - DWORD_B;
			end
			S_C0:  rd_addr = bp_q - WORD_B;
			S_C1: begin
				wr_en = 1'b1; wr_addr = bp_q - WORD_B;
				wr_val = split ? (need_a | addr_t'(ALLOC_BIT)) : (bs | addr_t'(ALLOC_BIT));
				rd_addr = bp_q - WORD_B;
			end
			S_C2A: begin
				wr_en = 1'b1; wr_addr = bp_q + bs - DWORD_B;
				wr_val = t_q | addr_t'(ALLOC_BIT);
			end
			S_C2B: begin
				wr_en = 1'b1; wr_addr = bp_q + bs - DWORD_B;
				wr_val = need_a | addr_t'(ALLOC_BIT);
				rd_addr = bp_q - WORD_B;
			end
			S_C3B: begin
				wr_en = 1'b1; wr_addr = bp_q + bs - WORD_B; wr_val = t_q - need_a;
				rd_addr = bp_q + bs - WORD_B;
			end
			S_C4B: begin
				wr_en = 1'b1; wr_addr = n_q + bs - DWORD_B; wr_val = t_q - need_a;
			end
			default: ;
		endcase
	end

	// sweep writes zeros plus the padding, prologue and epilogue words
	always_comb begin
		if (state_q == S_CLR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			if (clr_q == IW'(1) || clr_q == IW'(2)) ram_wdata = PRO_WORD;
			else if (clr_q == IW'(3)) ram_wdata = ALLOC_BIT;
			else ram_wdata = 32'd0;
		end else begin
			ram_we    = wr_en && in_heap(wr_addr);
			ram_waddr = wr_addr[IW+1:2];
			ram_wdata = wr_val[31:0];
		end
		ram_raddr = rd_addr[IW+1:2];
	end

	ffha_ram #(
		.WIDTH(32),
		.DEPTH(WORDS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			mode_q      <= MODE_INIT;
			clr_q       <= '0;
			brk_q       <= BW'(16);
			out_valid_q <= 1'b0;
			rvalid_q    <= 1'b0;
			fwd_q       <= 1'b0;
		end else begin
			state_q  <= state_d;
			rvalid_q <= in_heap(rd_addr);
			fwd_q    <= ram_we && (ram_waddr == ram_raddr);
			if (state_q == S_CLR) clr_q <= clr_q + IW'(1);
			if (state_q == S_G0 && !grow_fail) brk_q <= BW'(brk_a + gsz);
			if (accept) mode_q <= (req.func == FN_FREE) ? MODE_FREE : MODE_ALLOC;
			if (done_load) out_valid_q <= 1'b1;
			else if (rsp_ready) out_valid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		fwd_d_q <= ram_wdata;
		if (done_load) out_q <= res_q;
		unique case (state_q)
			S_CLR: t_q <= CHUNK_A;
			S_IDLE: begin
				bp_q   <= addr_t'(req.release_offset);
				need_q <= need_new;
				res_q  <= '{block_offset: 16'd0,
					status: (req.func == FN_ALLOC && req.request_bytes == 16'd0)
						? ST_ZERO : ST_OK};
			end
			S_F1:  t_q <= bs;
			S_A0:  bp_q <= DWORD_B;
			S_A1: begin
				if (bs == addr_t'(0)) t_q <= (need_a > CHUNK_A) ? need_a : CHUNK_A;
				else if (!fits) bp_q <= bp_q + bs;
			end
			S_G0: begin
				bp_q  <= brk_a;
				t_q   <= gsz;
				res_q <= '{block_offset: 16'd0, status: ST_FULL};
			end
			S_M1:  p_q  <= bp_q - bs;
			S_M3:  pa_q <= d[0];
			S_M5:  na_q <= d[0];
			S_M6:  sz_q <= bs;
			S_MA2: sz_q <= sz_q + bs;
			S_MB2: sz_q <= sz_q + bs;
			S_MB5: bp_q <= bp_q - bs;
			S_MC1: n_q  <= bp_q + bs;
			S_MC3: sz_q <= sz_q + bs;
			S_MC5: sz_q <= sz_q + bs;
			S_MC8: bp_q <= bp_q - bs;
			S_MRET: res_q <= '{block_offset: 16'd0, status: ST_OK};
			S_C1: begin
				t_q   <= bs;
				res_q <= '{block_offset: bp_q[15:0], status: ST_OK};
			end
			S_C3B: n_q <= bp_q + bs;
			default: ;
		endcase
	end

endmodule
`default_nettype wire
